FILE: hdl/cst_pkg.sv
// cst_pkg: shared types and constants of the token scanner
// beat payloads, token kind codes and default parameter values; no dependencies

package cst_pkg;

  localparam int unsigned KEYWORD_CHARS_DEF = 6;
  localparam int unsigned OFFSET_BITS_DEF   = 16;
  localparam int unsigned FIFO_DEPTH        = 4;

  localparam logic [2:0] KIND_NUMBER  = 3'd0;
  localparam logic [2:0] KIND_PUNCT   = 3'd1;
  localparam logic [2:0] KIND_IDENT   = 3'd2;
  localparam logic [2:0] KIND_KEYWORD = 3'd3;
  localparam logic [2:0] KIND_EOF     = 3'd4;
  localparam logic [2:0] KIND_INVALID = 3'd5;

  localparam logic [62:0] VALUE_MAX = {63{1'b1}};
  localparam logic [15:0] LEN_MAX   = 16'hFFFF;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       is_end;
  } text_beat_t;

  typedef struct packed {
    logic [2:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic [62:0] number_value;
    logic [7:0]  symbol_code;
    logic        last_of_run;
  } token_t;

endpackage

FILE: hdl/cst_stream_if.sv
// cst_stream_if: valid/ready stream channel with a typed payload
// used for the text input and token output of the scanner; no dependencies

interface cst_stream_if #(
  parameter type payload_t = logic
);
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

FILE: hdl/c_subset_token_scanner_core.sv
// c_subset_token_scanner_core: streaming lexer, one text byte per beat
// a token is written into the token queue as the byte that closes it is taken
// throughput: one byte per cycle; bytes giving two tokens drain through a
// four-entry token queue, which lowers ready when it has fewer than two free slots
// reset: asynchronous, clears scan mode, counters and queue; keyword prefix not reset
// depends on cst_pkg and cst_stream_if

module c_subset_token_scanner_core #(
  parameter int unsigned KEYWORD_CHARS = cst_pkg::KEYWORD_CHARS_DEF,
  parameter int unsigned OFFSET_BITS   = cst_pkg::OFFSET_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  cst_stream_if.sink     in_i,
  cst_stream_if.source   out_o
);

  localparam logic [1:0] MODE_IDLE = 2'd0;
  localparam logic [1:0] MODE_NUM  = 2'd1;
  localparam logic [1:0] MODE_WORD = 2'd2;

  localparam int unsigned PtrW = $clog2(cst_pkg::FIFO_DEPTH);
  localparam int unsigned CntW = PtrW + 1;

  logic [1:0]             mode_q, mode_d;
  logic [62:0]            acc_q, acc_d;
  logic [15:0]            pstart_q, pstart_d;
  logic [15:0]            plen_q, plen_d;
  logic [OFFSET_BITS-1:0] pos_q, pos_d;
  logic [7:0]             prefix_q [KEYWORD_CHARS];

  logic [PtrW-1:0]        wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]        count_q;
  cst_pkg::token_t        fifo_q [cst_pkg::FIFO_DEPTH];

  logic                   in_fire, pop;
  logic [7:0]             c;
  logic                   is_digit, is_alpha, is_space, is_punct, is_word_ch;
  logic [OFFSET_BITS+15:0] pos_ext;
  logic [15:0]            pos16;
  logic [OFFSET_BITS-1:0] pos_inc;
  logic [15:0]            plen_inc;
  logic [66:0]            acc_wide;
  logic [62:0]            acc_grow;
  logic                   kw;
  cst_pkg::token_t        res_a, res_b, first_tok;
  logic                   has_a, has_b;
  logic                   pfx_wr_en;
  logic [15:0]            pfx_wr_at;
  logic [1:0]             push_n;

  assign in_fire = in_i.valid && in_i.ready;
  assign c       = in_i.payload.text_byte;

  assign is_digit   = (c >= 8'h30) && (c <= 8'h39);
  assign is_alpha   = ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A));
  assign is_space   = (c == 8'h20) || ((c >= 8'd9) && (c <= 8'd13));
  assign is_word_ch = is_alpha || is_digit || (c == 8'h5F);
  assign is_punct   = (c == 8'h2B) || (c == 8'h2D) || (c == 8'h2A) || (c == 8'h2F) ||
                      (c == 8'h28) || (c == 8'h29) || (c == 8'h7B) || (c == 8'h7D) ||
                      (c == 8'h3B) || (c == 8'h3D);

  assign pos_ext  = {16'b0, pos_q};
  assign pos16    = pos_ext[15:0];
  assign pos_inc  = pos_q + {{(OFFSET_BITS-1){1'b0}}, 1'b1};
  assign plen_inc = (plen_q < cst_pkg::LEN_MAX) ? plen_q + 16'd1 : plen_q;

  // times ten plus digit, saturating
  assign acc_wide = {1'b0, acc_q, 3'b0} + {3'b0, acc_q, 1'b0} + {63'b0, c[3:0]};
  assign acc_grow = (acc_wide > {4'b0, cst_pkg::VALUE_MAX}) ? cst_pkg::VALUE_MAX
                                                             : acc_wide[62:0];

  assign kw = ((plen_q == 16'd6) && ({prefix_q[0], prefix_q[1], prefix_q[2], prefix_q[3],
                                      prefix_q[4], prefix_q[5]} == 48'("return"))) ||
              ((plen_q == 16'd3) && ({prefix_q[0], prefix_q[1], prefix_q[2]} == 24'("int"))) ||
              ((plen_q == 16'd2) && ({prefix_q[0], prefix_q[1]} == 16'("if"))) ||
              ((plen_q == 16'd4) && ({prefix_q[0], prefix_q[1], prefix_q[2],
                                      prefix_q[3]} == 32'("else"))) ||
              ((plen_q == 16'd5) && ({prefix_q[0], prefix_q[1], prefix_q[2], prefix_q[3],
                                      prefix_q[4]} == 40'("while"))) ||
              ((plen_q == 16'd3) && ({prefix_q[0], prefix_q[1], prefix_q[2]} == 24'("for")));

  always_comb begin
    mode_d    = mode_q;
    acc_d     = acc_q;
    pstart_d  = pstart_q;
    plen_d    = plen_q;
    pos_d     = pos_q;
    has_a     = 1'b0;
    has_b     = 1'b0;
    pfx_wr_en = 1'b0;
    pfx_wr_at = 16'd0;

    res_a              = '0;
    res_a.token_kind   = (mode_q == MODE_NUM) ? cst_pkg::KIND_NUMBER :
                         (kw ? cst_pkg::KIND_KEYWORD : cst_pkg::KIND_IDENT);
    res_a.token_start  = pstart_q;
    res_a.token_length = plen_q;
    res_a.number_value = (mode_q == MODE_NUM) ? acc_q : 63'd0;

    res_b              = '0;
    res_b.token_start  = pos16;
    res_b.last_of_run  = 1'b1;

    if (in_fire) begin
      if (in_i.payload.is_end) begin
        has_a             = (mode_q != MODE_IDLE);
        has_b             = 1'b1;
        res_b.token_kind  = cst_pkg::KIND_EOF;
        mode_d            = MODE_IDLE;
        acc_d             = '0;
        plen_d            = '0;
        pstart_d          = '0;
        pos_d             = '0;
      end else if ((mode_q == MODE_NUM) && is_digit) begin
        acc_d  = acc_grow;
        plen_d = plen_inc;
        pos_d  = pos_inc;
      end else if ((mode_q == MODE_WORD) && is_word_ch) begin
        pfx_wr_en = (plen_q < 16'(KEYWORD_CHARS));
        pfx_wr_at = plen_q;
        plen_d    = plen_inc;
        pos_d     = pos_inc;
      end else begin
        has_a  = (mode_q != MODE_IDLE);
        mode_d = MODE_IDLE;
        acc_d  = '0;
        plen_d = '0;
        pos_d  = pos_inc;
        priority if (is_space) begin
        end else if (is_digit) begin
          mode_d   = MODE_NUM;
          acc_d    = {59'b0, c[3:0]};
          pstart_d = pos16;
          plen_d   = 16'd1;
        end else if (is_alpha || (c == 8'h5F)) begin
          mode_d    = MODE_WORD;
          pfx_wr_en = 1'b1;
          pfx_wr_at = 16'd0;
          pstart_d  = pos16;
          plen_d    = 16'd1;
        end else if (is_punct) begin
          has_b              = 1'b1;
          res_b.token_kind   = cst_pkg::KIND_PUNCT;
          res_b.token_length = 16'd1;
          res_b.symbol_code  = c;
        end else begin
          has_b              = 1'b1;
          res_b.token_kind   = cst_pkg::KIND_INVALID;
          res_b.token_length = 16'd1;
          res_b.symbol_code  = c;
        end
      end
    end

    res_a.last_of_run = !has_b;
  end

  assign first_tok = has_a ? res_a : res_b;
  assign push_n    = {1'b0, has_a} + {1'b0, has_b};

  assign in_i.ready    = (count_q <= CntW'(cst_pkg::FIFO_DEPTH - 2));
  assign out_o.valid   = (count_q != '0);
  assign out_o.payload = fifo_q[rd_ptr_q];
  assign pop           = out_o.valid && out_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= MODE_IDLE;
      acc_q    <= '0;
      pstart_q <= '0;
      plen_q   <= '0;
      pos_q    <= '0;
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      mode_q   <= mode_d;
      acc_q    <= acc_d;
      pstart_q <= pstart_d;
      plen_q   <= plen_d;
      pos_q    <= pos_d;
      wr_ptr_q <= wr_ptr_q + PtrW'(push_n);
      rd_ptr_q <= rd_ptr_q + PtrW'(pop);
      count_q  <= count_q + CntW'(push_n) - CntW'(pop);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < KEYWORD_CHARS; i++) begin
      if (pfx_wr_en && (pfx_wr_at == 16'(i))) begin
        prefix_q[i] <= c;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (has_a || has_b) begin
      fifo_q[wr_ptr_q] <= first_tok;
    end
    if (has_a && has_b) begin
      fifo_q[wr_ptr_q + PtrW'(1)] <= res_b;
    end
  end

endmodule

FILE: hdl/cst_checker.sv
// cst_checker: port-level assertions for the token scanner, bound to the top level
// depends on cst_pkg and c_subset_token_scanner_core

module cst_checker (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_i,
  input logic            in_is_end_i,
  input logic            out_valid_i,
  input logic            out_ready_i,
  input cst_pkg::token_t out_beat_i
);

  // stalled token beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_beat_i))
    else $error("token beat changed while stalled");

  // end of text always yields a token beat next cycle
  a_end_emits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_is_end_i |=> out_valid_i)
    else $error("no token after end beat");

  // eof, punct and invalid tokens close their run
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && ((out_beat_i.token_kind == cst_pkg::KIND_EOF) ||
                    (out_beat_i.token_kind == cst_pkg::KIND_PUNCT) ||
                    (out_beat_i.token_kind == cst_pkg::KIND_INVALID))
    |-> out_beat_i.last_of_run)
    else $error("single-byte or eof token not last of run");

  // only number tokens carry a value
  a_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_beat_i.token_kind != cst_pkg::KIND_NUMBER)
    |-> (out_beat_i.number_value == '0))
    else $error("value on non-number token");

endmodule

bind c_subset_token_scanner_core cst_checker u_cst_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_is_end_i (in_i.payload.is_end),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_beat_i  (out_o.payload)
);

FILE: tb/sv/tb_token_checker.sv
// tb_token_checker: watches the text and token channels of the scanner, predicts the
// tokens of each accepted text beat and compares them with the tokens the block emits
// depends on cst_pkg
`timescale 1ns / 1ps

module tb_token_checker
  import cst_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       text_valid_i,
  input  logic       text_ready_i,
  input  text_beat_t text_beat_i,
  input  logic       token_valid_i,
  input  logic       token_ready_i,
  input  token_t     token_i,
  output int         mismatch_count_o,
  output int         open_tokens_o
);

  typedef enum logic [1:0] {
    SCAN_IDLE,
    SCAN_NUMBER,
    SCAN_WORD
  } scan_mode_e;

  string       kw_list [6] = '{"return", "int", "if", "else", "while", "for"};
  string       punct_chars = "+-*/(){};=";

  token_t      expected_tokens [$];
  scan_mode_e  mode;
  logic [62:0] num_acc;
  logic [15:0] tok_start;
  logic [15:0] tok_len;
  logic [15:0] text_pos;
  logic [7:0]  word_head [KEYWORD_CHARS_DEF];
  int          errors;

  assign mismatch_count_o = errors;

  function automatic bit is_digit(logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic bit is_letter(logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic bit is_space(logic [7:0] c);
    return c == " " || (c >= 8'd9 && c <= 8'd13);
  endfunction

  function automatic bit is_punct(logic [7:0] c);
    bit hit;
    hit = 1'b0;
    for (int i = 0; i < punct_chars.len(); i++)
      if (punct_chars[i] == c) hit = 1'b1;
    return hit;
  endfunction

  function automatic logic [2:0] word_kind();
    string kw;
    bit    same;
    for (int k = 0; k < 6; k++) begin
      kw = kw_list[k];
      if (tok_len == kw.len() && tok_len <= KEYWORD_CHARS_DEF) begin
        same = 1'b1;
        for (int i = 0; i < kw.len(); i++)
          if (word_head[i] != kw[i]) same = 1'b0;
        if (same) return KIND_KEYWORD;
      end
    end
    return KIND_IDENT;
  endfunction

  function automatic void push_token(logic [2:0] kind, logic [15:0] start, logic [15:0] len,
                                     logic [62:0] value, logic [7:0] sym);
    token_t t;
    t.token_kind   = kind;
    t.token_start  = start;
    t.token_length = len;
    t.number_value = value;
    t.symbol_code  = sym;
    t.last_of_run  = 1'b0;
    expected_tokens.push_back(t);
  endfunction

  function automatic void close_pending();
    if (mode == SCAN_NUMBER) push_token(KIND_NUMBER, tok_start, tok_len, num_acc, 8'd0);
    else if (mode == SCAN_WORD) push_token(word_kind(), tok_start, tok_len, '0, 8'd0);
    mode    = SCAN_IDLE;
    num_acc = '0;
    tok_len = '0;
  endfunction

  function automatic void grow_length();
    if (tok_len != LEN_MAX) tok_len++;
  endfunction

  function automatic void scan_byte(text_beat_t beat);
    int          queued;
    logic [7:0]  c;
    logic [63:0] digit;
    queued = expected_tokens.size();
    c      = beat.text_byte;
    digit  = 64'(c) - 64'd48;
    if (beat.is_end) begin
      close_pending();
      push_token(KIND_EOF, text_pos, 16'd0, '0, 8'd0);
      tok_start = '0;
      text_pos  = '0;
      expected_tokens[$].last_of_run = 1'b1;
      return;
    end
    if (mode == SCAN_NUMBER) begin
      if (is_digit(c)) begin
        if ({1'b0, num_acc} > ({1'b0, VALUE_MAX} - digit) / 64'd10) num_acc = VALUE_MAX;
        else num_acc = 63'(num_acc * 63'd10 + digit);
        grow_length();
        text_pos++;
        return;
      end
      close_pending();
    end else if (mode == SCAN_WORD) begin
      if (is_letter(c) || is_digit(c) || c == "_") begin
        if (tok_len < KEYWORD_CHARS_DEF) word_head[tok_len] = c;
        grow_length();
        text_pos++;
        return;
      end
      close_pending();
    end
    if (is_space(c)) begin
    end else if (is_digit(c)) begin
      mode      = SCAN_NUMBER;
      num_acc   = 63'(digit);
      tok_start = text_pos;
      tok_len   = 16'd1;
    end else if (is_letter(c) || c == "_") begin
      mode         = SCAN_WORD;
      word_head[0] = c;
      tok_start    = text_pos;
      tok_len      = 16'd1;
    end else if (is_punct(c)) begin
      push_token(KIND_PUNCT, text_pos, 16'd1, '0, c);
    end else begin
      push_token(KIND_INVALID, text_pos, 16'd1, '0, c);
    end
    text_pos++;
    if (expected_tokens.size() > queued) expected_tokens[$].last_of_run = 1'b1;
  endfunction

  function automatic void check_token(token_t got);
    token_t want;
    if (expected_tokens.size() == 0) begin
      if (errors < 10)
        $display("unexpected token: kind %0d start %0d len %0d value %0d sym %0h last %0b",
                 got.token_kind, got.token_start, got.token_length, got.number_value,
                 got.symbol_code, got.last_of_run);
      errors++;
      return;
    end
    want = expected_tokens.pop_front();
    if (got.token_kind !== want.token_kind || got.token_start !== want.token_start ||
        got.token_length !== want.token_length || got.number_value !== want.number_value ||
        got.symbol_code !== want.symbol_code || got.last_of_run !== want.last_of_run) begin
      if (errors < 10) begin
        $display("token mismatch: exp kind %0d start %0d len %0d value %0d sym %0h last %0b",
                 want.token_kind, want.token_start, want.token_length, want.number_value,
                 want.symbol_code, want.last_of_run);
        $display("                got kind %0d start %0d len %0d value %0d sym %0h last %0b",
                 got.token_kind, got.token_start, got.token_length, got.number_value,
                 got.symbol_code, got.last_of_run);
      end
      errors++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_tokens.delete();
      mode          = SCAN_IDLE;
      num_acc       = '0;
      tok_start     = '0;
      tok_len       = '0;
      text_pos      = '0;
      errors        = 0;
      open_tokens_o <= 0;
    end else begin
      if (token_valid_i && token_ready_i) check_token(token_i);
      if (text_valid_i && text_ready_i) scan_byte(text_beat_i);
      open_tokens_o <= expected_tokens.size();
    end
  end

endmodule

FILE: tb/sv/tb_c_subset_token_scanner_core.sv
// tb_c_subset_token_scanner_core: drives source text into the scanner in bursts,
// stalls the token side, and reports the verdict from the token checker
// depends on cst_pkg, cst_stream_if, c_subset_token_scanner_core and tb_token_checker
`timescale 1ns / 1ps

module tb_c_subset_token_scanner_core;
  import cst_pkg::*;

  localparam int RANDOM_ITEMS = 1780;
  localparam int HOLD_CYCLES  = 400;
  localparam int LONG_RUN     = 20;
  localparam int SETTLE       = 20;

  logic  clk_i  = 1'b0;
  logic  rst_ni = 1'b0;
  int    mismatches;
  int    open_tokens;
  bit    hold_req  = 1'b0;
  bit    no_gaps   = 1'b0;
  int    burst_left = 0;
  int    items_sent = 0;
  string kw_list [6] = '{"return", "int", "if", "else", "while", "for"};
  string punct_chars = "+-*/(){};=";
  string odd_chars   = "!\"#$%&',.:<>?@[\\]^`|~";

  always #5 clk_i = ~clk_i;

  cst_stream_if #(.payload_t(text_beat_t)) text_ch ();
  cst_stream_if #(.payload_t(token_t))     token_ch ();

  c_subset_token_scanner_core DUT (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (text_ch),
    .out_o (token_ch)
  );

  tb_token_checker token_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .text_valid_i    (text_ch.valid),
    .text_ready_i    (text_ch.ready),
    .text_beat_i     (text_ch.payload),
    .token_valid_i   (token_ch.valid),
    .token_ready_i   (token_ch.ready),
    .token_i         (token_ch.payload),
    .mismatch_count_o(mismatches),
    .open_tokens_o   (open_tokens)
  );

  task automatic send_beat(input logic [7:0] b, input logic e);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 3);
      if (!no_gaps && gap > 0) begin
        text_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    text_ch.valid   <= 1'b1;
    text_ch.payload <= '{text_byte: b, is_end: e};
    @(posedge clk_i);
    while (!text_ch.ready) @(posedge clk_i);
    burst_left--;
    items_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_beat(s[i], 1'b0);
  endtask

  task automatic wait_drained();
    text_ch.valid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (open_tokens != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] word_char();
    int r;
    r = $urandom_range(0, 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r < 62) return 8'("0" + r - 52);
    return "_";
  endfunction

  function automatic logic [7:0] space_char();
    if ($urandom_range(0, 1) == 0) return " ";
    return 8'($urandom_range(9, 13));
  endfunction

  function automatic logic [7:0] invalid_char();
    case ($urandom_range(0, 3))
      0: return 8'($urandom_range(0, 8));
      1: return 8'($urandom_range(128, 255));
      2: return odd_chars[$urandom_range(0, odd_chars.len() - 1)];
      default: return ($urandom_range(0, 4) == 0) ? 8'd127 : 8'($urandom_range(14, 31));
    endcase
  endfunction

  task automatic send_number();
    int len;
    bit nines;
    case ($urandom_range(0, 19))
      0: send_text("9223372036854775807");
      1: send_text("9223372036854775808");
      2: send_text("922337203685477580");
      default: begin
        len   = ($urandom_range(0, 9) == 0) ? $urandom_range(18, 24) : $urandom_range(1, 4);
        nines = ($urandom_range(0, 3) == 0);
        for (int i = 0; i < len; i++)
          send_beat(nines ? 8'("9") : 8'("0" + $urandom_range(0, 9)), 1'b0);
      end
    endcase
  endtask

  task automatic send_lexeme();
    int    r;
    int    len;
    string kw;
    r = $urandom_range(0, 99);
    if (r < 15) begin
      send_text(kw_list[$urandom_range(0, 5)]);
    end else if (r < 22) begin
      kw = kw_list[$urandom_range(0, 5)];
      case ($urandom_range(0, 2))
        0: send_text(kw.substr(0, kw.len() - 2));
        1: begin
          send_text(kw);
          send_beat(word_char(), 1'b0);
        end
        default: begin
          kw[0] = 8'(kw[0] - 8'd32);
          send_text(kw);
        end
      endcase
    end else if (r < 40) begin
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 8);
      send_beat(($urandom_range(0, 5) == 0) ? 8'("_") : 8'("a" + $urandom_range(0, 25)),
                1'b0);
      for (int i = 1; i < len; i++) send_beat(word_char(), 1'b0);
    end else if (r < 58) begin
      send_number();
    end else if (r < 75) begin
      send_beat(punct_chars[$urandom_range(0, 9)], 1'b0);
    end else if (r < 80) begin
      send_beat(invalid_char(), 1'b0);
    end else if (r < 90) begin
      send_beat(8'($urandom_range(0, 255)), 1'b0);
    end else begin
      repeat ($urandom_range(1, 3)) send_beat(space_char(), 1'b0);
    end
  endtask

  initial begin : token_sink
    int phase_left;
    int stall_style;
    int tick;
    phase_left     = 0;
    stall_style    = 0;
    tick           = 0;
    token_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      tick++;
      if (hold_req) begin
        token_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_req = 1'b0;
      end else begin
        if (phase_left == 0) begin
          stall_style = $urandom_range(0, 4);
          phase_left  = $urandom_range(20, 200);
        end
        phase_left--;
        case (stall_style)
          0: token_ch.ready <= 1'b1;
          1: token_ch.ready <= ($urandom_range(0, 1) == 0);
          2: token_ch.ready <= ($urandom_range(0, 3) == 0);
          3: token_ch.ready <= ($urandom_range(0, 9) != 0);
          default: token_ch.ready <= (tick % 3 != 0);
        endcase
      end
    end
  end

  initial begin : text_source
    int stage;
    stage           = 0;
    text_ch.valid   = 1'b0;
    text_ch.payload = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // number closed by punct, every punct, odd bytes, word closed by end, empty text, number closed by end
    send_text("0+-*/(){};=");
    send_beat(8'h00, 1'b0);
    send_beat(8'hFF, 1'b0);
    send_beat(8'h80, 1'b0);
    send_beat(8'h09, 1'b0);
    send_text("_a9");
    send_beat(8'hA5, 1'b1);
    send_beat(8'h00, 1'b1);
    send_text("7");
    send_beat(8'h5A, 1'b1);
    wait_drained();

    items_sent = 0;
    while (items_sent < RANDOM_ITEMS) begin
      send_lexeme();
      if ($urandom_range(0, 2) != 0) send_beat(space_char(), 1'b0);
      if ($urandom_range(0, 39) == 0) send_beat(8'($urandom_range(0, 255)), 1'b1);
      if (stage == 0 && items_sent > 500) begin
        hold_req = 1'b1;
        stage    = 1;
      end else if (stage == 1 && items_sent > 900) begin
        wait_drained();
        stage = 2;
      end else if (stage == 2 && items_sent > 1300) begin
        hold_req = 1'b1;
        stage    = 3;
      end
    end
    send_beat(8'($urandom_range(0, 255)), 1'b1);

    // long word and long number sent back to back
    no_gaps = 1'b1;
    send_beat("x", 1'b0);
    for (int i = 0; i < LONG_RUN; i++) send_beat(word_char(), 1'b0);
    send_beat(" ", 1'b0);
    for (int i = 0; i < LONG_RUN; i++) send_beat(8'("0" + $urandom_range(0, 9)), 1'b0);
    send_text(" if ;");
    send_beat(8'h00, 1'b1);
    no_gaps = 1'b0;

    wait_drained();
    repeat (SETTLE) @(posedge clk_i);
    if (mismatches == 0 && open_tokens == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  initial begin : watchdog
    #(20_000_000);
    $display("tb: failure");
    $finish;
  end

endmodule
